@@ rtl/mvt_pkg.sv @@
// Shared types, widths and constants for the matrix vertex transform pipeline.
package mvt_pkg;

    localparam int WORD_W        = 32;
    localparam int PROD_W        = 2 * WORD_W;
    localparam int PAIR_W        = PROD_W + 1;
    localparam int SUM_W         = PROD_W + 2;
    localparam int NUM_ROWS      = 4;
    localparam int NUM_COLS      = 4;
    localparam int CFG_NUM       = 8;
    localparam int CFG_W         = 64;
    localparam int CFG_IDX_W     = 4;
    localparam int CFG_SEL_W     = $clog2(CFG_NUM);
    localparam int DEF_FRAC_BITS = 16;

    // High nibble enables the column terms of a row, low nibble names its lane.
    localparam logic [7:0] ROW_MASK [NUM_ROWS] = '{8'hF1, 8'hF2, 8'hF4, 8'hF8};

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [PAIR_W-1:0] t_pair;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef logic [CFG_W-1:0]         t_cfg;

    typedef t_word t_vec  [NUM_COLS];
    typedef t_word t_mat  [NUM_ROWS][NUM_COLS];
    typedef t_prod t_prods[NUM_ROWS][NUM_COLS];
    typedef t_sum  t_sums [NUM_ROWS];

    typedef struct packed {
        logic valid;
        logic last;
    } t_ctl;

endpackage

@@ rtl/matrix_vertex_transform_unit.sv @@
// Top level: 4x4 matrix times vertex in signed fixed point, five register stages deep.
// A transferred vertex moves through the input, product, pair, row-sum and output registers to o_valid.
// One vertex is taken every cycle; the sixteen multipliers and the adder tree are pipelined.
// busy stays low, and results are shown for one cycle since the receiver cannot stall.
// Synchronous active-low reset clears all valid bits and loads the identity matrix.
module matrix_vertex_transform_unit #(
    parameter int FRAC_BITS = mvt_pkg::DEF_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_cfg_we,
    input  logic [mvt_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  mvt_pkg::t_cfg                 i_cfg_data,
    input  mvt_pkg::t_word                i_vx_in,
    input  mvt_pkg::t_word                i_vy_in,
    input  mvt_pkg::t_word                i_vz_in,
    input  mvt_pkg::t_word                i_vw_in,
    input  logic                          i_last_in,
    output logic                          o_valid,
    output mvt_pkg::t_word                o_vx_out,
    output mvt_pkg::t_word                o_vy_out,
    output mvt_pkg::t_word                o_vz_out,
    output mvt_pkg::t_word                o_vw_out,
    output logic                          o_saturated,
    output logic                          o_last_out
);
    import mvt_pkg::*;

    t_mat   coef;
    t_ctl   in_ctl;
    t_vec   in_vec;
    t_ctl   mul_ctl;
    t_prods mul_prod;
    t_ctl   add_ctl;
    t_sums  add_sum;
    t_ctl   out_ctl;
    t_vec   out_vec;

    assign busy         = 1'b0;
    assign in_ctl.valid = start && !busy;
    assign in_ctl.last  = i_last_in;
    assign in_vec       = '{i_vx_in, i_vy_in, i_vz_in, i_vw_in};

    mvt_cfg_regs #(
        .FRAC_BITS (FRAC_BITS)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_coef  (coef)
    );

    mvt_mul_stage u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (in_ctl),
        .i_vec   (in_vec),
        .i_coef  (coef),
        .o_ctl   (mul_ctl),
        .o_prod  (mul_prod)
    );

    mvt_add_tree u_add (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mul_ctl),
        .i_prod  (mul_prod),
        .o_ctl   (add_ctl),
        .o_sum   (add_sum)
    );

    mvt_sat_stage #(
        .FRAC_BITS (FRAC_BITS)
    ) u_sat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (add_ctl),
        .i_sum   (add_sum),
        .o_ctl   (out_ctl),
        .o_vec   (out_vec),
        .o_sat   (o_saturated)
    );

    assign o_valid    = out_ctl.valid;
    assign o_last_out = out_ctl.last;
    assign o_vx_out   = out_vec[0];
    assign o_vy_out   = out_vec[1];
    assign o_vz_out   = out_vec[2];
    assign o_vw_out   = out_vec[3];

    localparam t_word WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam t_word WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    a_transfer_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##5 o_valid)
        else $error("accepted vertex produced no result");

    a_no_invented_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !start |-> ##5 !o_valid)
        else $error("result strobe without an accepted vertex");

    a_last_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##5 (o_last_out == $past(i_last_in, 5)))
        else $error("last mark lost in the pipeline");

    a_sat_means_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |->
            (o_vx_out == WORD_MAX || o_vx_out == WORD_MIN ||
             o_vy_out == WORD_MAX || o_vy_out == WORD_MIN ||
             o_vz_out == WORD_MAX || o_vz_out == WORD_MIN ||
             o_vw_out == WORD_MAX || o_vw_out == WORD_MIN))
        else $error("saturation flag set with no clamped component");

endmodule

@@ rtl/mvt_cfg_regs.sv @@
// Matrix coefficient register file with identity reset and plain write port.
module mvt_cfg_regs #(
    parameter int FRAC_BITS = mvt_pkg::DEF_FRAC_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_we,
    input  logic [mvt_pkg::CFG_IDX_W-1:0]  i_idx,
    input  mvt_pkg::t_cfg                  i_data,
    output mvt_pkg::t_mat                  o_coef
);
    import mvt_pkg::*;

    t_cfg r_regs [CFG_NUM];

    function automatic t_cfg reset_val(input int unsigned idx);
        t_cfg        v;
        int unsigned row;
        v = '0;
        for (row = 0; row < NUM_ROWS; row++) begin
            if ((row * 2 + (row >> 1)) == idx) begin
                v[WORD_W*(row & 1) +: WORD_W] = WORD_W'(64'd1 << FRAC_BITS);
            end
        end
        return v;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CFG_NUM; i++) begin
                r_regs[i] <= reset_val(i);
            end
        end else if (i_we && (i_idx < CFG_IDX_W'(CFG_NUM))) begin
            r_regs[i_idx[CFG_SEL_W-1:0]] <= i_data;
        end
    end

    always_comb begin
        for (int r = 0; r < NUM_ROWS; r++) begin
            for (int c = 0; c < NUM_COLS; c++) begin
                o_coef[r][c] = r_regs[r*2 + (c >> 1)][WORD_W*(c & 1) +: WORD_W];
            end
        end
    end

endmodule

@@ rtl/mvt_mul_stage.sv @@
// Vertex input register followed by sixteen registered signed multiplies.
module mvt_mul_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mvt_pkg::t_ctl   i_ctl,
    input  mvt_pkg::t_vec   i_vec,
    input  mvt_pkg::t_mat   i_coef,
    output mvt_pkg::t_ctl   o_ctl,
    output mvt_pkg::t_prods o_prod
);
    import mvt_pkg::*;

    t_ctl  r_in_ctl;
    t_vec  r_vec;
    t_ctl  r_prod_ctl;
    t_prods r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_ctl   <= '0;
            r_prod_ctl <= '0;
        end else begin
            r_in_ctl   <= i_ctl;
            r_prod_ctl <= r_in_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vec <= i_vec;
        for (int r = 0; r < NUM_ROWS; r++) begin
            for (int c = 0; c < NUM_COLS; c++) begin
                if (ROW_MASK[r][4 + c]) begin
                    r_prod[r][c] <= i_coef[r][c] * r_vec[c];
                end else begin
                    r_prod[r][c] <= '0;
                end
            end
        end
    end

    assign o_ctl  = r_prod_ctl;
    assign o_prod = r_prod;

endmodule

@@ rtl/mvt_add_tree.sv @@
// Two-level registered adder tree that sums the four products of each row exactly.
module mvt_add_tree (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mvt_pkg::t_ctl   i_ctl,
    input  mvt_pkg::t_prods i_prod,
    output mvt_pkg::t_ctl   o_ctl,
    output mvt_pkg::t_sums  o_sum
);
    import mvt_pkg::*;

    t_ctl  r_pair_ctl;
    t_pair r_pair [NUM_ROWS][2];
    t_ctl  r_sum_ctl;
    t_sums r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_ctl <= '0;
            r_sum_ctl  <= '0;
        end else begin
            r_pair_ctl <= i_ctl;
            r_sum_ctl  <= r_pair_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int r = 0; r < NUM_ROWS; r++) begin
            r_pair[r][0] <= PAIR_W'(i_prod[r][0]) + PAIR_W'(i_prod[r][1]);
            r_pair[r][1] <= PAIR_W'(i_prod[r][2]) + PAIR_W'(i_prod[r][3]);
            r_sum[r]     <= SUM_W'(r_pair[r][0]) + SUM_W'(r_pair[r][1]);
        end
    end

    assign o_ctl = r_sum_ctl;
    assign o_sum = r_sum;

endmodule

@@ rtl/mvt_sat_stage.sv @@
// Arithmetic shift by the fraction width, saturation to 32 bits and output registers.
module mvt_sat_stage #(
    parameter int FRAC_BITS = mvt_pkg::DEF_FRAC_BITS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mvt_pkg::t_ctl  i_ctl,
    input  mvt_pkg::t_sums i_sum,
    output mvt_pkg::t_ctl  o_ctl,
    output mvt_pkg::t_vec  o_vec,
    output logic           o_sat
);
    import mvt_pkg::*;

    localparam int SHR_W = SUM_W - FRAC_BITS;

    t_ctl r_ctl;
    t_vec r_vec;
    logic r_sat;
    t_vec n_vec;
    logic n_sat;

    always_comb begin
        logic signed [SHR_W-1:0]      sh;
        logic [SHR_W-WORD_W:0]        top;
        n_sat = 1'b0;
        for (int r = 0; r < NUM_ROWS; r++) begin
            sh  = i_sum[r][SUM_W-1:FRAC_BITS];
            top = sh[SHR_W-1:WORD_W-1];
            if ((top == '0) || (top == '1)) begin
                n_vec[r] = sh[WORD_W-1:0];
            end else begin
                n_sat    = 1'b1;
                n_vec[r] = sh[SHR_W-1] ? {1'b1, {(WORD_W-1){1'b0}}}
                                       : {1'b0, {(WORD_W-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vec <= n_vec;
        r_sat <= n_sat;
    end

    assign o_ctl = r_ctl;
    assign o_vec = r_vec;
    assign o_sat = r_sat;

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the matrix vertex transform unit with a built-in fixed-point predictor.
module tb;
    import mvt_pkg::*;

    localparam int FRAC_BITS    = DEF_FRAC_BITS;
    localparam int NUM_PHASES   = 12;
    localparam int RANDOM_ITEMS = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;

    localparam logic signed [SUM_W-1:0] LANE_MAX = 2147483647;
    localparam logic signed [SUM_W-1:0] LANE_MIN = -LANE_MAX - 1;
    localparam t_word Q_ONE = t_word'(1 << FRAC_BITS);

    typedef struct packed {
        t_word vx;
        t_word vy;
        t_word vz;
        t_word vw;
        logic  last;
    } t_vertex;

    typedef struct packed {
        t_word vx;
        t_word vy;
        t_word vz;
        t_word vw;
        logic  sat;
        logic  last;
    } t_xformed;

    logic                 i_clk;
    logic                 i_rst_n    = 1'b0;
    logic                 start      = 1'b0;
    logic                 busy;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    t_cfg                 i_cfg_data = '0;
    t_vertex              cur_vertex = '0;
    logic                 o_valid;
    t_word                o_vx_out;
    t_word                o_vy_out;
    t_word                o_vz_out;
    t_word                o_vw_out;
    logic                 o_saturated;
    logic                 o_last_out;

    t_word    matrix_q [NUM_ROWS][NUM_COLS];
    t_vertex  pending_vertices[$];
    t_xformed predicted_results[$];
    t_vertex  next_vertex;
    t_xformed seen_result = '0;
    t_xformed want_result;
    logic     seen_valid  = 1'b0;
    int       gap_left    = 0;
    int       burst_left  = 1;
    int       mismatches  = 0;
    int       cycle_count = 0;

    matrix_vertex_transform_unit #(
        .FRAC_BITS (FRAC_BITS)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_vx_in     (cur_vertex.vx),
        .i_vy_in     (cur_vertex.vy),
        .i_vz_in     (cur_vertex.vz),
        .i_vw_in     (cur_vertex.vw),
        .i_last_in   (cur_vertex.last),
        .o_valid     (o_valid),
        .o_vx_out    (o_vx_out),
        .o_vy_out    (o_vy_out),
        .o_vz_out    (o_vz_out),
        .o_vw_out    (o_vw_out),
        .o_saturated (o_saturated),
        .o_last_out  (o_last_out)
    );

    function automatic t_xformed transform_vertex(input t_vertex v);
        t_xformed                res;
        t_word                   comp [NUM_COLS];
        t_word                   lane [NUM_ROWS];
        logic signed [SUM_W-1:0] acc;
        logic signed [SUM_W-1:0] coef_x;
        logic signed [SUM_W-1:0] comp_x;
        logic                    sat;
        comp[0] = v.vx;
        comp[1] = v.vy;
        comp[2] = v.vz;
        comp[3] = v.vw;
        sat = 1'b0;
        for (int r = 0; r < NUM_ROWS; r++) begin
            acc = '0;
            for (int c = 0; c < NUM_COLS; c++) begin
                if (ROW_MASK[r][4+c]) begin
                    coef_x = matrix_q[r][c];
                    comp_x = comp[c];
                    acc = acc + coef_x * comp_x;
                end
            end
            acc = acc >>> FRAC_BITS;
            if (acc > LANE_MAX) begin
                lane[r] = LANE_MAX[WORD_W-1:0];
                sat = 1'b1;
            end else if (acc < LANE_MIN) begin
                lane[r] = LANE_MIN[WORD_W-1:0];
                sat = 1'b1;
            end else begin
                lane[r] = acc[WORD_W-1:0];
            end
        end
        res.vx   = lane[0];
        res.vy   = lane[1];
        res.vz   = lane[2];
        res.vw   = lane[3];
        res.sat  = sat;
        res.last = v.last;
        return res;
    endfunction

    function automatic t_word random_component();
        case ($urandom_range(0, 9))
            0: return LANE_MAX[WORD_W-1:0];
            1: return LANE_MIN[WORD_W-1:0];
            2: return '0;
            3: return t_word'(int'($urandom_range(0, 262144)) - 131072);
            4, 5: return t_word'(int'($urandom_range(0, 33554432)) - 16777216);
            default: return t_word'($urandom());
        endcase
    endfunction

    function automatic t_word random_coeff();
        case ($urandom_range(0, 9))
            0: return Q_ONE;
            1: return -Q_ONE;
            2: return '0;
            3, 4, 5: return t_word'(int'($urandom_range(0, 524288)) - 262144);
            6: return LANE_MAX[WORD_W-1:0];
            7: return LANE_MIN[WORD_W-1:0];
            default: return t_word'($urandom());
        endcase
    endfunction

    function automatic t_vertex random_vertex();
        t_vertex v;
        v.vx   = random_component();
        v.vy   = random_component();
        v.vz   = random_component();
        v.vw   = random_component();
        v.last = ($urandom_range(0, 7) == 0);
        return v;
    endfunction

    task automatic write_matrix_reg(input int idx, input t_cfg data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx[CFG_IDX_W-1:0];
        i_cfg_data <= data;
        if (idx < CFG_NUM) begin
            matrix_q[idx / 2][(idx % 2) * 2]     = data[WORD_W-1:0];
            matrix_q[idx / 2][(idx % 2) * 2 + 1] = data[CFG_W-1:WORD_W];
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_vertices.size() != 0 || start || predicted_results.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t %s mismatch: expected %0d, actual %0d", $time, name,
                     $signed(want), $signed(got));
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t timeout with %0d results outstanding", $time,
                     predicted_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Sender: a transfer happens on every edge with start high and busy low.
    always @(posedge i_clk) begin
        if (start && !busy) begin
            predicted_results.push_back(transform_vertex(cur_vertex));
        end
        if (start && busy) begin
            start <= 1'b1;
        end else if (gap_left != 0) begin
            start    <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (pending_vertices.size() != 0) begin
            next_vertex = pending_vertices.pop_front();
            cur_vertex <= next_vertex;
            start      <= 1'b1;
            if (burst_left <= 1) begin
                burst_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                          : $urandom_range(1, 32);
                gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            start <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        seen_valid  <= (i_rst_n === 1'b1) && (o_valid === 1'b1);
        seen_result <= {o_vx_out, o_vy_out, o_vz_out, o_vw_out, o_saturated, o_last_out};
    end

    always @(negedge i_clk) begin
        if (seen_valid) begin
            if (predicted_results.size() == 0) begin
                mismatches++;
                $display("%0t unexpected result: expected none, actual %p", $time,
                         seen_result);
            end else begin
                want_result = predicted_results.pop_front();
                check_field("vx_out", want_result.vx, seen_result.vx);
                check_field("vy_out", want_result.vy, seen_result.vy);
                check_field("vz_out", want_result.vz, seen_result.vz);
                check_field("vw_out", want_result.vw, seen_result.vw);
                check_field("saturated", {31'b0, want_result.sat}, {31'b0, seen_result.sat});
                check_field("last_out", {31'b0, want_result.last}, {31'b0, seen_result.last});
            end
        end
    end

    initial begin
        t_vertex directed [8];
        t_cfg    fill;
        int      per_phase;
        directed[0] = '{vx: 0, vy: 0, vz: 0, vw: 0, last: 1'b0};
        directed[1] = '{vx: LANE_MAX[31:0], vy: LANE_MAX[31:0], vz: LANE_MAX[31:0],
                        vw: LANE_MAX[31:0], last: 1'b0};
        directed[2] = '{vx: LANE_MIN[31:0], vy: LANE_MIN[31:0], vz: LANE_MIN[31:0],
                        vw: LANE_MIN[31:0], last: 1'b1};
        directed[3] = '{vx: -1, vy: -1, vz: -1, vw: -1, last: 1'b1};
        directed[4] = '{vx: 1, vy: 1, vz: 1, vw: 1, last: 1'b0};
        directed[5] = '{vx: LANE_MAX[31:0], vy: LANE_MIN[31:0], vz: LANE_MAX[31:0],
                        vw: LANE_MIN[31:0], last: 1'b1};
        directed[6] = '{vx: 32'h55555555, vy: 32'hAAAAAAAA, vz: 32'h55555555,
                        vw: 32'hAAAAAAAA, last: 1'b0};
        directed[7] = '{vx: -196603, vy: 98305, vz: -3, vw: Q_ONE, last: 1'b1};
        per_phase = RANDOM_ITEMS / NUM_PHASES;
        for (int r = 0; r < NUM_ROWS; r++) begin
            for (int c = 0; c < NUM_COLS; c++) begin
                matrix_q[r][c] = (r == c) ? Q_ONE : '0;
            end
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            wait_drained();
            if (phase != 0) begin
                case (phase)
                    1: fill = 64'h7FFFFFFF_7FFFFFFF;
                    2: fill = 64'h00000001_00000001;
                    3: fill = 64'h80000000_80000000;
                    4: fill = '0;
                    5: fill = '1;
                    default: fill = '0;
                endcase
                for (int idx = 0; idx < CFG_NUM; idx++) begin
                    write_matrix_reg(idx, (phase > 5) ? {random_coeff(), random_coeff()} : fill);
                end
                // Writes to indexes past the last register must leave the matrix alone.
                for (int k = 0; k < 2; k++) begin
                    write_matrix_reg($urandom_range(CFG_NUM, 2 ** CFG_IDX_W - 1),
                                     {$urandom(), $urandom()});
                end
                @(posedge i_clk);
                i_cfg_we <= 1'b0;
                @(negedge i_clk);
            end
            if (phase < 3) begin
                foreach (directed[i]) pending_vertices.push_back(directed[i]);
            end
            for (int n = 0; n < per_phase; n++) begin
                pending_vertices.push_back(random_vertex());
            end
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

@@ matrix_vertex_transform_unit.f @@
rtl/mvt_pkg.sv
rtl/mvt_cfg_regs.sv
rtl/mvt_mul_stage.sv
rtl/mvt_add_tree.sv
rtl/mvt_sat_stage.sv
rtl/matrix_vertex_transform_unit.sv
dv/tb.sv
